/* hdl/scnbtn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Scanned button debouncer package
// Shared constants, register indexes, word types and control structs.
// ----------------------------------------------------------------------------
package scnbtn_pkg;

    localparam int unsigned MAX_BUTTONS_DEF = 8;
    localparam int unsigned POS_W           = 3;
    localparam int unsigned COUNT_W         = 4;
    localparam int unsigned CNT_W           = 8;
    localparam int unsigned KEY_W           = 8;
    localparam int unsigned CFG_DATA_W      = 64;

    localparam logic [CNT_W-1:0]      CNT_MAX       = 8'd255;
    localparam logic [CNT_W-1:0]      THR_ZERO_EFF  = 8'd2;
    localparam logic [COUNT_W-1:0]    COUNT_RST     = 4'd8;
    localparam logic [CNT_W-1:0]      THR_RST       = 8'd2;
    localparam logic                  LEVEL_RST     = 1'b0;
    localparam logic [CFG_DATA_W-1:0] KEY_TABLE_RST = 64'd0;

    typedef enum logic [1:0] {
        CFG_BUTTON_COUNT = 2'd0,
        CFG_THRESHOLD    = 2'd1,
        CFG_ACTIVE_LEVEL = 2'd2,
        CFG_KEY_TABLE    = 2'd3
    } t_cfg_index;

    typedef enum logic {
        ACT_SCAN     = 1'b0,
        ACT_READ_KEY = 1'b1
    } t_action;

    typedef struct packed {
        t_action          action;
        logic             line_level;
        logic [POS_W-1:0] query_index;
    } t_in_word;

    typedef struct packed {
        logic             query_pressed;
        logic [KEY_W-1:0] key_code;
    } t_out_word;

    typedef struct packed {
        logic             pressed;
        logic [CNT_W-1:0] threshold;
    } t_lane_ctl;

endpackage
`default_nettype wire

/* hdl/scanned_button_debouncer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Scanned button debouncer
// Debounces up to MAX_BUTTONS round-robin scanned buttons and latches keys.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the output side is not stalled and
// returns exactly one result word per input word, in order. A word is held in
// the input register, the combinational lane update and key latch then run
// and load the output register, from which the result is presented. Sustained
// rate is one word per cycle when the output side is not stalled. The user
// must write configuration through the plain write port only while no word
// is in flight; the block itself does not enforce this.
module scanned_button_debouncer
    import scnbtn_pkg::*;
#(
    parameter int unsigned MAX_BUTTONS = MAX_BUTTONS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_word                  o_out_word,
    input  wire logic                  i_cfg_wr_en,
    input  wire t_cfg_index            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    logic [COUNT_W-1:0]    r_num_buttons;
    logic [CNT_W-1:0]      r_threshold;
    logic                  r_press_level;
    logic [CFG_DATA_W-1:0] r_key_table;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      w_advance;
    logic      w_in_take;
    t_out_word w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buttons <= COUNT_RST;
            r_threshold   <= THR_RST;
            r_press_level <= LEVEL_RST;
            r_key_table   <= KEY_TABLE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BUTTON_COUNT: r_num_buttons <= i_cfg_wr_data[COUNT_W-1:0];
                CFG_THRESHOLD:    r_threshold   <= i_cfg_wr_data[CNT_W-1:0];
                CFG_ACTIVE_LEVEL: r_press_level <= i_cfg_wr_data[0];
                CFG_KEY_TABLE:    r_key_table   <= i_cfg_wr_data;
            endcase
        end
    end

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_word <= i_in_word;
        end
    end

    scnbtn_core #(
        .MAX_BUTTONS (MAX_BUTTONS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_advance),
        .i_word        (r_in_word),
        .i_num_buttons (r_num_buttons),
        .i_threshold   (r_threshold),
        .i_press_level (r_press_level),
        .i_key_table   (r_key_table),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stall raised with no word held");

    a_scan_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_word.action == ACT_SCAN)) |=> (o_out_word.key_code == '0))
        else $error("scan word produced a nonzero key code");

    a_out_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_advance))
        else $error("result word appeared without an advance");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !w_advance)
        else $error("output register overwritten while stalled");

endmodule
`default_nettype wire

/* hdl/scnbtn_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Scanned button debouncer lane
// Stable state and saturating change counter of one button.
// ----------------------------------------------------------------------------
module scnbtn_lane
    import scnbtn_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  wire t_lane_ctl i_ctl,
    output logic           o_stable,
    output logic           o_stable_next,
    output logic           o_rise
);

    logic             r_stable;
    logic             n_stable;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] w_cnt_inc;

    assign w_cnt_inc = (r_cnt == CNT_MAX) ? CNT_MAX : r_cnt + CNT_W'(1);

    always_comb begin
        n_stable = r_stable;
        n_cnt    = r_cnt;
        o_rise   = 1'b0;
        if (i_en) begin
            if (i_ctl.pressed == r_stable) begin
                n_cnt = '0;
            end else begin
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= i_ctl.threshold) begin
                    n_stable = i_ctl.pressed;
                    n_cnt    = '0;
                    o_rise   = i_ctl.pressed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_stable <= n_stable;
            r_cnt    <= n_cnt;
        end
    end

    assign o_stable      = r_stable;
    assign o_stable_next = n_stable;

endmodule
`default_nettype wire

/* hdl/scnbtn_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Scanned button debouncer core
// Scan position, button lanes, key latch and query selection for one word.
// ----------------------------------------------------------------------------
module scnbtn_core
    import scnbtn_pkg::*;
#(
    parameter int unsigned MAX_BUTTONS = MAX_BUTTONS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_in_word              i_word,
    input  wire logic [COUNT_W-1:0]    i_num_buttons,
    input  wire logic [CNT_W-1:0]      i_threshold,
    input  wire logic                  i_press_level,
    input  wire logic [CFG_DATA_W-1:0] i_key_table,
    output t_out_word                  o_result
);

    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    logic [KEY_W-1:0]       r_key;
    logic [KEY_W-1:0]       n_key;
    logic [COUNT_W-1:0]     w_count;
    logic [POS_W-1:0]       w_idx;
    logic [COUNT_W-1:0]     w_idx_inc;
    logic                   w_scan;
    t_lane_ctl              w_ctl;
    logic [MAX_BUTTONS-1:0] w_stable;
    logic [MAX_BUTTONS-1:0] w_stable_next;
    logic [MAX_BUTTONS-1:0] w_rise;
    logic                   w_query_state;

    always_comb begin
        if (i_num_buttons == '0) begin
            w_count = COUNT_W'(1);
        end else if (i_num_buttons > COUNT_W'(MAX_BUTTONS)) begin
            w_count = COUNT_W'(MAX_BUTTONS);
        end else begin
            w_count = i_num_buttons;
        end
    end

    assign w_scan    = i_en && (i_word.action == ACT_SCAN);
    assign w_idx     = ({1'b0, r_pos} >= w_count) ? '0 : r_pos;
    assign w_idx_inc = {1'b0, w_idx} + COUNT_W'(1);
    assign n_pos     = w_scan ? ((w_idx_inc >= w_count) ? '0 : w_idx_inc[POS_W-1:0]) : r_pos;

    assign w_ctl.pressed   = (i_word.line_level == i_press_level);
    assign w_ctl.threshold = (i_threshold == '0) ? THR_ZERO_EFF : i_threshold;

    for (genvar g = 0; g < MAX_BUTTONS; g++) begin : g_lane
        scnbtn_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (w_scan && (w_idx == POS_W'(g))),
            .i_ctl         (w_ctl),
            .o_stable      (w_stable[g]),
            .o_stable_next (w_stable_next[g]),
            .o_rise        (w_rise[g])
        );
    end

    always_comb begin
        n_key = r_key;
        if (i_en) begin
            if (i_word.action == ACT_READ_KEY) begin
                n_key = '0;
            end else if (|w_rise) begin
                n_key = i_key_table[{w_idx, 3'b000} +: KEY_W];
            end
        end
    end

    always_comb begin
        w_query_state = 1'b0;
        for (int i = 0; i < MAX_BUTTONS; i++) begin
            if (i_word.query_index == POS_W'(i)) begin
                w_query_state = i_en ? w_stable_next[i] : w_stable[i];
            end
        end
    end

    assign o_result.query_pressed =
        ({1'b0, i_word.query_index} < w_count) ? w_query_state : 1'b0;
    assign o_result.key_code = (i_word.action == ACT_READ_KEY) ? r_key : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_key <= '0;
        end else begin
            r_pos <= n_pos;
            r_key <= n_key;
        end
    end

endmodule
`default_nettype wire

/* verif/scanned_button_debouncer_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Scanned button debouncer testbench
// Drives scan and read-key words through the valid/stall channels with random
// gaps and stalls. It rewrites the configuration between phases and checks
// every result word against an in-order prediction of the debounce state.
// ----------------------------------------------------------------------------
module scanned_button_debouncer_tb;
    import scnbtn_pkg::*;

    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 10;

    class debounce_scoreboard;
        logic [COUNT_W-1:0]    num_buttons;
        logic [CNT_W-1:0]      threshold;
        logic                  press_level;
        logic [CFG_DATA_W-1:0] key_table;
        bit                    stable_pressed [MAX_BUTTONS_DEF];
        bit [CNT_W-1:0]        change_cnt [MAX_BUTTONS_DEF];
        bit [POS_W-1:0]        scan_pos;
        bit [KEY_W-1:0]        latched_key;
        t_out_word             expected_q [$];
        int                    errors;

        function new();
            num_buttons = COUNT_RST;
            threshold   = THR_RST;
            press_level = LEVEL_RST;
            key_table   = KEY_TABLE_RST;
            foreach (stable_pressed[i]) begin
                stable_pressed[i] = 1'b0;
                change_cnt[i]     = '0;
            end
            scan_pos    = '0;
            latched_key = '0;
            errors      = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BUTTON_COUNT: num_buttons = data[COUNT_W-1:0];
                CFG_THRESHOLD:    threshold   = data[CNT_W-1:0];
                CFG_ACTIVE_LEVEL: press_level = data[0];
                CFG_KEY_TABLE:    key_table   = data;
                default: ;
            endcase
        endfunction

        function int eff_count();
            if (num_buttons == 0) return 1;
            if (num_buttons > MAX_BUTTONS_DEF) return MAX_BUTTONS_DEF;
            return int'(num_buttons);
        endfunction

        function int eff_threshold();
            return (threshold == 0) ? int'(THR_ZERO_EFF) : int'(threshold);
        endfunction

        function int next_button();
            return (scan_pos >= eff_count()) ? 0 : int'(scan_pos);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(t_in_word w);
            int             count;
            int             idx;
            bit             pressed;
            bit [KEY_W-1:0] key;
            t_out_word      e;
            count = eff_count();
            key   = '0;
            if (w.action == ACT_SCAN) begin
                idx     = next_button();
                pressed = (w.line_level == press_level);
                if (pressed == stable_pressed[idx]) begin
                    change_cnt[idx] = '0;
                end else begin
                    if (change_cnt[idx] != CNT_MAX) change_cnt[idx]++;
                    if (change_cnt[idx] >= eff_threshold()) begin
                        stable_pressed[idx] = pressed;
                        change_cnt[idx]     = '0;
                        if (pressed) latched_key = key_table[8*idx +: KEY_W];
                    end
                end
                idx++;
                if (idx >= count) idx = 0;
                scan_pos = POS_W'(idx);
            end else begin
                key         = latched_key;
                latched_key = '0;
            end
            e.query_pressed = (w.query_index < count) ? stable_pressed[w.query_index] : 1'b0;
            e.key_code      = key;
            expected_q.push_back(e);
        endfunction

        function void check_result(t_out_word r);
            t_out_word e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, r);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (r.query_pressed !== e.query_pressed) begin
                $display("%0t: query_pressed expected %0b actual %0b",
                         $time, e.query_pressed, r.query_pressed);
                errors++;
            end
            if (r.key_code !== e.key_code) begin
                $display("%0t: key_code expected %02h actual %02h",
                         $time, e.key_code, r.key_code);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_wr_en;
    t_cfg_index            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;

    debounce_scoreboard sb = new();

    bit                       idle_on = 1'b1;
    bit                       hold_request = 1'b0;
    int                       hold_left = 0;
    int                       stall_left = 0;
    int                       quiet_cycles = 0;
    bit [MAX_BUTTONS_DEF-1:0] target_level = '0;

    scanned_button_debouncer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_word     (i_in_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_word);
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL scanned_button_debouncer");
            $finish;
        end
    end

    function automatic t_in_word make_word(t_action act, logic level, int query);
        t_in_word w;
        w.action      = act;
        w.line_level  = level;
        w.query_index = POS_W'(query);
        return w;
    endfunction

    function automatic t_in_word random_word(int noise_pct, int flip_div);
        t_in_word w;
        int       b;
        w.action      = ($urandom_range(0, 99) < 12) ? ACT_READ_KEY : ACT_SCAN;
        w.line_level  = 1'($urandom_range(0, 1));
        w.query_index = POS_W'($urandom_range(0, 7));
        if (w.action == ACT_SCAN && $urandom_range(0, 99) >= 10) begin
            b = sb.next_button();
            if ($urandom_range(1, flip_div) == 1) target_level[b] = ~target_level[b];
            w.line_level = target_level[b] ^ ($urandom_range(0, 99) < noise_pct);
        end
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        if (idle_on && hold_left == 0 && !hold_request && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic write_config(int count, int thr, bit level, logic [CFG_DATA_W-1:0] keys);
        settle();
        write_reg(CFG_BUTTON_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_ACTIVE_LEVEL, CFG_DATA_W'(level));
        write_reg(CFG_KEY_TABLE, keys);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int                    count;
        int                    thr;
        int                    n_words;
        int                    noise_pct;
        int                    flip_div;
        logic [CFG_DATA_W-1:0] keys;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_word     <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= CFG_BUTTON_COUNT;
        i_cfg_wr_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(make_word(ACT_READ_KEY, 1'b0, 7));
        send_word(make_word(ACT_SCAN, 1'b0, 0));
        send_word(make_word(ACT_SCAN, 1'b1, 7));

        write_config(1, 0, 1'b1, 64'h0123_4567_89AB_CDEF);
        send_word(make_word(ACT_SCAN, 1'b1, 0));
        send_word(make_word(ACT_SCAN, 1'b1, 0));
        send_word(make_word(ACT_SCAN, 1'b1, 1));
        send_word(make_word(ACT_READ_KEY, 1'b0, 0));
        send_word(make_word(ACT_READ_KEY, 1'b1, 0));
        send_word(make_word(ACT_SCAN, 1'b0, 0));
        send_word(make_word(ACT_SCAN, 1'b0, 0));
        send_word(make_word(ACT_READ_KEY, 1'b0, 0));

        write_config(0, 1, 1'b0, 64'hFFFF_FFFF_FFFF_FF00);
        send_word(make_word(ACT_SCAN, 1'b0, 0));
        send_word(make_word(ACT_READ_KEY, 1'b0, 7));
        send_word(make_word(ACT_SCAN, 1'b1, 0));

        write_config(15, 255, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(make_word(ACT_SCAN, 1'b1, 7));
        send_word(make_word(ACT_SCAN, 1'b0, 3));
        send_word(make_word(ACT_READ_KEY, 1'b1, 5));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       count = 8;
                1:       count = 1;
                2:       count = 15;
                3:       count = 0;
                default: count = $urandom_range(0, 15);
            endcase
            case (p)
                1:       thr = 255;
                2:       thr = 0;
                3:       thr = 1;
                default: thr = $urandom_range(0, 4);
            endcase
            keys = {$urandom, $urandom};
            if (p % 2 == 1) keys[8*$urandom_range(0, 7) +: 8] = '0;
            write_config(count, thr, p % 2, keys);
            idle_on   = (p < PHASES - 2);
            n_words   = (p == 1) ? 320 : 100;
            noise_pct = (thr > 8) ? 0 : 8;
            flip_div  = (thr > 8) ? 600 : 10;
            for (int i = 0; i < n_words; i++) begin
                if (p == 5 && i == 20) hold_request = 1'b1;
                send_word(random_word(noise_pct, flip_div));
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS scanned_button_debouncer");
        end else begin
            $display("FAIL scanned_button_debouncer");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
hdl/scnbtn_pkg.sv
hdl/scnbtn_lane.sv
hdl/scnbtn_core.sv
hdl/scanned_button_debouncer.sv
verif/scanned_button_debouncer_tb.sv
